### src/torus_minimal_route_queue_select_defines.svh
// assertion macros used by the torus route selector top level
`ifndef TORUS_MINIMAL_ROUTE_QUEUE_SELECT_DEFINES_SVH
`define TORUS_MINIMAL_ROUTE_QUEUE_SELECT_DEFINES_SVH

// property checked at every edge outside reset
`define TMRQS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define TMRQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### src/tmrqs_pkg.sv
// shared constants, types and helpers of the torus route selector
package tmrqs_pkg;

  localparam int Dims       = 3;
  localparam int MaxRadix   = 16;
  localparam int AddrW      = 12;
  localparam int SizeW      = 5;
  localparam int ClassW     = 2;
  localparam int MaskW      = 6;
  localparam int CoordW     = $clog2(MaxRadix);
  localparam int RadixW     = $clog2(MaxRadix + 1);
  localparam int DimW       = (Dims > 1) ? $clog2(Dims) : 1;
  localparam int RecipShift = AddrW + CoordW;
  localparam int RecipW     = RecipShift + 1;
  localparam int NumSizeRegs = 3;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = AddrW;
  localparam int NumStages  = 2 * Dims + 1;

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CoordW-1:0] coord_t;
  typedef logic [RadixW-1:0] radix_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegSizeX   = 2'd0,
    RegSizeY   = 2'd1,
    RegSizeZ   = 2'd2,
    RegOwnAddr = 2'd3
  } cfg_reg_e;

  // central queue classes
  typedef enum logic [ClassW-1:0] {
    ClassA = 2'd0,
    ClassB = 2'd1,
    ClassC = 2'd2
  } queue_class_e;

  typedef struct packed {
    logic [AddrW-1:0]  dest_address;
    logic [ClassW-1:0] queue_class;
  } in_t;

  typedef struct packed {
    logic              at_destination;
    logic [MaskW-1:0]  direction_mask;
    logic [ClassW-1:0] next_queue_class;
    logic              address_error;
  } out_t;

  // item state while the coordinates are peeled off one dimension at a time
  typedef struct packed {
    addr_t                 dest_quo;
    addr_t                 own_quo;
    coord_t [Dims-1:0]     dest_c;
    coord_t [Dims-1:0]     own_c;
    logic   [ClassW-1:0]   cls;
    logic                  at_dest;
  } work_t;

  // stage enables of one dimension split unit
  typedef struct packed {
    logic en_mul;
    logic en_sub;
  } split_ctrl_t;

  // size register to usable radix: zero acts as one, clamp at the maximum
  function automatic radix_t eff_size(logic [SizeW-1:0] size);
    radix_t res;
    if (size == '0) begin
      res = radix_t'(1);
    end else if (int'(size) > MaxRadix) begin
      res = radix_t'(MaxRadix);
    end else begin
      res = radix_t'(size);
    end
    return res;
  endfunction

endpackage

### src/tmrqs_split.sv
// one dimension of the mixed-radix split: reciprocal multiply, then remainder
module tmrqs_split (
  input  logic                           clk_i,
  input  tmrqs_pkg::split_ctrl_t         ctrl_i,
  input  logic [tmrqs_pkg::DimW-1:0]     dim_i,
  input  tmrqs_pkg::radix_t              radix_i,
  input  tmrqs_pkg::work_t               work_i,
  output tmrqs_pkg::work_t               work_o
);

  localparam int ProdW = tmrqs_pkg::AddrW + tmrqs_pkg::RecipW;
  localparam int RemW  = tmrqs_pkg::AddrW + tmrqs_pkg::RadixW;

  // reciprocal table, ceil(2^shift / k), exact for every address below 2^AddrW
  logic [tmrqs_pkg::RecipW-1:0] recip [tmrqs_pkg::MaxRadix+1];

  assign recip[0] = '0;
  for (genvar Rdx = 1; Rdx <= tmrqs_pkg::MaxRadix; Rdx++) begin : g_recip
    localparam int Recip = ((1 << tmrqs_pkg::RecipShift) + Rdx - 1) / Rdx;
    assign recip[Rdx] = tmrqs_pkg::RecipW'(Recip);
  end

  // stage a: quotients by reciprocal multiplication
  logic [ProdW-1:0]     prod_dest, prod_own;
  tmrqs_pkg::addr_t     quo_dest_d, quo_own_d;
  tmrqs_pkg::addr_t     quo_dest_q, quo_own_q;
  tmrqs_pkg::work_t     work_a_q;

  always_comb begin
    prod_dest  = ProdW'(work_i.dest_quo) * ProdW'(recip[radix_i]);
    prod_own   = ProdW'(work_i.own_quo) * ProdW'(recip[radix_i]);
    quo_dest_d = prod_dest[tmrqs_pkg::RecipShift +: tmrqs_pkg::AddrW];
    quo_own_d  = prod_own[tmrqs_pkg::RecipShift +: tmrqs_pkg::AddrW];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      work_a_q   <= work_i;
      quo_dest_q <= quo_dest_d;
      quo_own_q  <= quo_own_d;
    end
  end

  // stage b: remainders become this dimension's coordinates
  logic [RemW-1:0]  rem_dest, rem_own;
  tmrqs_pkg::work_t work_b_d, work_b_q;

  always_comb begin
    rem_dest = RemW'(work_a_q.dest_quo) - RemW'(quo_dest_q) * RemW'(radix_i);
    rem_own  = RemW'(work_a_q.own_quo) - RemW'(quo_own_q) * RemW'(radix_i);
    work_b_d = work_a_q;
    work_b_d.dest_quo        = quo_dest_q;
    work_b_d.own_quo         = quo_own_q;
    work_b_d.dest_c[dim_i]   = rem_dest[tmrqs_pkg::CoordW-1:0];
    work_b_d.own_c[dim_i]    = rem_own[tmrqs_pkg::CoordW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_sub) begin
      work_b_q <= work_b_d;
    end
  end

  assign work_o = work_b_q;

endmodule

### src/tmrqs_route.sv
// minimal direction per dimension, arrival, address error and queue class
module tmrqs_route (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  tmrqs_pkg::radix_t [tmrqs_pkg::Dims-1:0]  radix_i,
  input  tmrqs_pkg::work_t                         work_i,
  output tmrqs_pkg::out_t                          out_o
);

  localparam int RadixW = tmrqs_pkg::RadixW;

  tmrqs_pkg::out_t       out_d, out_q;
  logic [tmrqs_pkg::MaskW-1:0] mask;
  tmrqs_pkg::queue_class_e     next_cls;
  logic                        higher, lower;

  // shorter way round in every dimension, ties go plus
  always_comb begin
    logic [RadixW-1:0] here, there, k, off;
    logic              at_last, at_first;
    mask   = '0;
    higher = 1'b0;
    lower  = 1'b0;
    for (int d = 0; d < tmrqs_pkg::Dims; d++) begin
      here     = RadixW'(work_i.own_c[d]);
      there    = RadixW'(work_i.dest_c[d]);
      k        = radix_i[d];
      if (there >= here) begin
        off = there - here;
      end else begin
        off = there + k - here;
      end
      at_last  = (here == k - RadixW'(1));
      at_first = (here == '0);
      if (off != '0) begin
        if (off <= (k >> 1)) begin
          mask[2*d] = 1'b1;
          if (!at_last) higher = 1'b1;
          else          lower  = 1'b1;
        end else begin
          mask[2*d+1] = 1'b1;
          if (at_first) higher = 1'b1;
          else          lower  = 1'b1;
        end
      end
    end
  end

  // queue class ordering rule
  always_comb begin
    case (work_i.cls)
      tmrqs_pkg::ClassA: next_cls = higher ? tmrqs_pkg::ClassA : tmrqs_pkg::ClassB;
      tmrqs_pkg::ClassB: next_cls = lower ? tmrqs_pkg::ClassB : tmrqs_pkg::ClassC;
      default:           next_cls = tmrqs_pkg::ClassC;
    endcase
  end

  always_comb begin
    out_d.at_destination   = work_i.at_dest;
    out_d.direction_mask   = mask;
    out_d.next_queue_class = next_cls;
    out_d.address_error    = (work_i.dest_quo != '0);
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

### src/torus_minimal_route_queue_select.sv
// top level of the torus minimal route and queue class selector
//
// Usage: a packet header enters on the in channel (destination address and
// current queue class) with a valid/ready transfer; one result leaves on
// the out channel per header: arrival flag, six-bit minimal direction mask,
// next queue class and an address error flag. Torus sizes and this router's
// address sit in four registers written through the cfg port (index, data,
// write enable); write them only while no header is in flight.
// Stages: two per dimension (reciprocal multiply, then remainder multiply and
// subtract) plus the route and class stage, which is also the output
// register. Throughput: one header per cycle while out_ready_i is high;
// each stage holds its own multipliers.
// Reset: clears all stage valid bits, sizes return to 4 and the own address
// to 0; the block is ready for a header straight out of reset.
// Stall: when out_ready_i is low the pipeline holds; empty stages still
// close up, so in_ready_o only drops once every stage holds a header.
`include "torus_minimal_route_queue_select_defines.svh"

module torus_minimal_route_queue_select (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tmrqs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tmrqs_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tmrqs_pkg::in_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tmrqs_pkg::out_t                    out_data_o
);

  localparam int NumStages = tmrqs_pkg::NumStages;
  localparam int Dims      = tmrqs_pkg::Dims;

  // configuration registers
  logic [tmrqs_pkg::SizeW-1:0] size_q [tmrqs_pkg::NumSizeRegs];
  tmrqs_pkg::addr_t            own_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tmrqs_pkg::NumSizeRegs; i++) begin
        size_q[i] <= tmrqs_pkg::SizeW'(4);
      end
      own_q <= '0;
    end else if (cfg_we_i) begin
      case (tmrqs_pkg::cfg_reg_e'(cfg_idx_i))
        tmrqs_pkg::RegSizeX:   size_q[0] <= cfg_wdata_i[tmrqs_pkg::SizeW-1:0];
        tmrqs_pkg::RegSizeY:   size_q[1] <= cfg_wdata_i[tmrqs_pkg::SizeW-1:0];
        tmrqs_pkg::RegSizeZ:   size_q[2] <= cfg_wdata_i[tmrqs_pkg::SizeW-1:0];
        tmrqs_pkg::RegOwnAddr: own_q     <= cfg_wdata_i[tmrqs_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  // usable radix per dimension
  tmrqs_pkg::radix_t [Dims-1:0] radix;

  always_comb begin
    for (int d = 0; d < Dims; d++) begin
      radix[d] = tmrqs_pkg::eff_size(size_q[d]);
    end
  end

  // stage enables: a stage loads when it is empty or its successor moves
  logic [NumStages:0]   en;
  logic [NumStages-1:0] valid_d, valid_q;

  always_comb begin
    en[NumStages] = out_ready_i;
    for (int s = NumStages - 1; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int s = 1; s < NumStages; s++) begin
      valid_d[s] = en[s] ? valid_q[s-1] : valid_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];

  // header as it enters the split chain
  tmrqs_pkg::work_t work [Dims+1];

  always_comb begin
    work[0]          = '0;
    work[0].dest_quo = in_data_i.dest_address;
    work[0].own_quo  = own_q;
    work[0].cls      = in_data_i.queue_class;
    work[0].at_dest  = (in_data_i.dest_address == own_q);
  end

  // one split unit per dimension, x first
  for (genvar d = 0; d < Dims; d++) begin : g_dim
    tmrqs_pkg::split_ctrl_t ctrl;

    assign ctrl.en_mul = en[2*d];
    assign ctrl.en_sub = en[2*d+1];

    tmrqs_split u_split (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .dim_i   (tmrqs_pkg::DimW'(d)),
      .radix_i (radix[d]),
      .work_i  (work[d]),
      .work_o  (work[d+1])
    );
  end

  tmrqs_route u_route (
    .clk_i   (clk_i),
    .en_i    (en[2*Dims]),
    .radix_i (radix),
    .work_i  (work[Dims]),
    .out_o   (out_data_o)
  );

  // checks
  `TMRQS_ASSERT_ALWAYS(a_blocked_means_full, !in_ready_o |-> (&valid_q), "input blocked with a free stage")
  `TMRQS_ASSERT_ALWAYS(a_one_entry_per_cycle, $countones(valid_q) <= $countones($past(valid_q)) + 1, "more than one header entered in a cycle")
  `TMRQS_ASSERT_ALWAYS(a_arrived_no_move, (out_valid_o && out_data_o.at_destination) |-> (out_data_o.direction_mask == '0), "move requested at destination")
  `TMRQS_ASSERT_ALWAYS(a_class_a_needs_move, (out_valid_o && out_data_o.next_queue_class == tmrqs_pkg::ClassA) |-> (out_data_o.direction_mask != '0), "class A kept without a minimal move")
  `TMRQS_ASSERT_NEXT(a_head_holds, valid_q[0] && !en[1], valid_q[0], "first stage dropped a stalled header")

endmodule
